### src/hhe_pkg.sv
package hhe_pkg;

   // result kinds
   typedef enum logic [2:0] {
      KIND_HOST_BYTE  = 3'd0,
      KIND_HOST_DONE  = 3'd1,
      KIND_BAD_METHOD = 3'd2,
      KIND_NO_HEADER  = 3'd3,
      KIND_EMPTY_HOST = 3'd4,
      KIND_TOO_LONG   = 3'd5,
      KIND_TRUNCATED  = 3'd6
   } kind_type;

   // parser phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_METHOD = 5'b00010,
      PH_URI    = 5'b00100,
      PH_HDR    = 5'b01000,
      PH_HOST   = 5'b10000
   } phase_type;

   localparam logic [4:0] GET_LEN  = 5'd5;
   localparam logic [4:0] POST_LEN = 5'd6;
   localparam logic [4:0] HDR_LEN  = 5'd17;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_P     = 8'h50;

   // queue between parser and output side
   localparam int QUEUE_DEPTH = 4;
   localparam int QPW         = $clog2(QUEUE_DEPTH);

   // one result
   typedef struct packed {
      logic [7:0] host_char;
      kind_type   kind;
   } res_type;

   // results of one request: one or two
   typedef struct packed {
      logic    two;
      res_type r0;
      res_type r1;
   } entry_type;

   // "GET /" or "POST /" character at a position
   function automatic logic [7:0] method_char(input logic post, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (post) begin
         case (pos)
            3'd0: ch = "P";
            3'd1: ch = "O";
            3'd2: ch = "S";
            3'd3: ch = "T";
            3'd4: ch = " ";
            3'd5: ch = "/";
            default: ch = 8'h00;
         endcase
      end else begin
         case (pos)
            3'd0: ch = "G";
            3'd1: ch = "E";
            3'd2: ch = "T";
            3'd3: ch = " ";
            3'd4: ch = "/";
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

   // " HTTP/1.1\r\nHost: " character at a position
   function automatic logic [7:0] hdr_char(input logic [4:0] pos);
      logic [7:0] ch;
      case (pos)
         5'd0:  ch = " ";
         5'd1:  ch = "H";
         5'd2:  ch = "T";
         5'd3:  ch = "T";
         5'd4:  ch = "P";
         5'd5:  ch = "/";
         5'd6:  ch = "1";
         5'd7:  ch = ".";
         5'd8:  ch = "1";
         5'd9:  ch = 8'h0D;
         5'd10: ch = 8'h0A;
         5'd11: ch = "H";
         5'd12: ch = "o";
         5'd13: ch = "s";
         5'd14: ch = "t";
         5'd15: ch = ":";
         5'd16: ch = " ";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### src/hhe_front.sv
module hhe_front
   import hhe_pkg::*;
#(
   parameter int MAX_NAME_LEN = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_final_byte,
   output logic       push,
   output entry_type  entry
);

   localparam int NLW = $clog2(MAX_NAME_LEN);
   localparam logic [NLW-1:0] NAME_LIMIT = NLW'(MAX_NAME_LEN - 1);

   phase_type      phase_ff, phase_in, phase_eff;
   logic [4:0]     mp_ff, mp_in, mp_eff, mp_inc;
   logic           post_ff, post_in, post_eff, post_now;
   logic [NLW-1:0] nl_ff, nl_in, nl_eff;
   logic           dot_ff, dot_in, dot_eff;
   logic           accept, pre_close;
   logic [4:0]     mlen;
   kind_type       closing, end_kind;
   logic [1:0]     body_n;
   res_type        b0, b1, pre_res, end_res;

   assign accept = req_valid & req_ready;

   // next parser state and the results of this request
   always_comb begin
      pre_close = req_first_byte && (phase_ff != PH_IDLE);
      phase_eff = req_first_byte ? PH_METHOD : phase_ff;
      mp_eff    = req_first_byte ? 5'd0 : mp_ff;
      post_eff  = req_first_byte ? 1'b0 : post_ff;
      nl_eff    = req_first_byte ? '0 : nl_ff;
      dot_eff   = req_first_byte ? 1'b0 : dot_ff;

      phase_in = phase_eff;
      mp_in    = mp_eff;
      post_in  = post_eff;
      nl_in    = nl_eff;
      dot_in   = dot_eff;
      mp_inc   = 5'(mp_eff + 5'd1);
      post_now = post_eff;
      mlen     = GET_LEN;
      closing  = KIND_HOST_BYTE;
      body_n   = 2'd0;
      b0       = '0;
      b1       = '0;

      unique case (phase_eff)
         PH_IDLE: begin
         end
         PH_METHOD: begin
            post_now = (mp_eff == 5'd0) ? (req_data_byte == CH_P) : post_eff;
            post_in  = post_now;
            mlen     = post_now ? POST_LEN : GET_LEN;
            if (mp_eff >= mlen || req_data_byte != method_char(post_now, mp_eff[2:0])) begin
               closing = KIND_BAD_METHOD;
            end else if (mp_inc == mlen) begin
               phase_in = PH_URI;
               mp_in    = 5'd0;
            end else begin
               mp_in = mp_inc;
            end
         end
         PH_URI: begin
            if (req_data_byte == CH_SPACE) begin
               phase_in = PH_HDR;
               mp_in    = 5'd1;
            end
         end
         PH_HDR: begin
            if (mp_eff >= HDR_LEN || req_data_byte != hdr_char(mp_eff)) begin
               closing = KIND_NO_HEADER;
            end else if (mp_inc == HDR_LEN) begin
               phase_in = PH_HOST;
               mp_in    = 5'd0;
            end else begin
               mp_in = mp_inc;
            end
         end
         PH_HOST: begin
            if (req_data_byte == CH_CR) begin
               closing = (nl_eff == NLW'(dot_eff)) ? KIND_EMPTY_HOST : KIND_HOST_DONE;
            end else if (nl_eff >= NAME_LIMIT) begin
               closing = KIND_TOO_LONG;
            end else begin
               nl_in = NLW'(nl_eff + 1'b1);
               // a held dot goes out ahead of this byte
               if (dot_eff) begin
                  b0     = '{host_char: CH_DOT, kind: KIND_HOST_BYTE};
                  body_n = 2'd1;
               end
               if (req_data_byte == CH_DOT) begin
                  dot_in = 1'b1;
               end else begin
                  dot_in = 1'b0;
                  if (dot_eff) begin
                     b1 = '{host_char: req_data_byte, kind: KIND_HOST_BYTE};
                  end else begin
                     b0 = '{host_char: req_data_byte, kind: KIND_HOST_BYTE};
                  end
                  body_n = 2'(body_n + 2'd1);
               end
            end
         end
         default: begin
         end
      endcase

      // closing result replaces any host bytes of this request
      if (closing != KIND_HOST_BYTE) begin
         end_kind = closing;
      end else if (req_final_byte && phase_eff != PH_IDLE) begin
         end_kind = KIND_TRUNCATED;
      end else begin
         end_kind = KIND_HOST_BYTE;
      end
      if (end_kind != KIND_HOST_BYTE) begin
         phase_in = PH_IDLE;
         mp_in    = 5'd0;
         post_in  = 1'b0;
         nl_in    = '0;
         dot_in   = 1'b0;
      end

      pre_res = '{host_char: 8'h00, kind: KIND_TRUNCATED};
      end_res = '{host_char: 8'h00, kind: end_kind};

      // pack results in order
      entry = '0;
      push  = 1'b0;
      if (pre_close) begin
         entry.r0  = pre_res;
         entry.r1  = end_res;
         entry.two = (end_kind != KIND_HOST_BYTE);
         push      = accept;
      end else if (end_kind != KIND_HOST_BYTE) begin
         entry.r0 = end_res;
         push     = accept;
      end else begin
         entry.r0  = b0;
         entry.r1  = b1;
         entry.two = (body_n == 2'd2);
         push      = accept && (body_n != 2'd0);
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mp_ff    <= 5'd0;
         post_ff  <= 1'b0;
         nl_ff    <= '0;
         dot_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         mp_ff    <= mp_in;
         post_ff  <= post_in;
         nl_ff    <= nl_in;
         dot_ff   <= dot_in;
      end
   end

`ifndef ASSERT_OFF
   // name length never passes the limit
   a_name_len: assert property (@(posedge clock) disable iff (reset)
      nl_ff <= NAME_LIMIT)
      else $error("host name length past limit");

   // a held dot only exists while reading the host
   a_dot_phase: assert property (@(posedge clock) disable iff (reset)
      dot_ff |-> (phase_ff == PH_HOST && nl_ff != '0))
      else $error("dot held outside host phase");
`endif

endmodule

### src/hhe_queue.sv
module hhe_queue
   import hhe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPW:0]     cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QPW+1)'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ff];

   // pointers and fill count
   always_comb begin
      wr_in  = push ? QPW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? QPW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = (QPW+1)'(cnt_ff + (QPW+1)'(push) - (QPW+1)'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue underflow");
`endif

endmodule

### src/hhe_back.sv
module hhe_back
   import hhe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_host_char,
   output logic [2:0] rsp_kind,
   output logic       rsp_is_last
);

   logic    sel_ff, sel_in;
   res_type cur;

   // walk the one or two results of the head entry
   always_comb begin
      cur       = sel_ff ? head.r1 : head.r0;
      rsp_valid = !empty;
      pop       = 1'b0;
      sel_in    = sel_ff;
      if (rsp_valid && rsp_ready) begin
         if (head.two && !sel_ff) begin
            sel_in = 1'b1;
         end else begin
            sel_in = 1'b0;
            pop    = 1'b1;
         end
      end
   end

   assign rsp_host_char = cur.host_char;
   assign rsp_kind      = cur.kind;
   assign rsp_is_last   = (cur.kind != KIND_HOST_BYTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

`ifndef ASSERT_OFF
   // second slot only selected for a two-result entry
   a_sel_two: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (!empty && head.two))
      else $error("second result selected on single entry");
`endif

endmodule

### src/http_host_extractor.sv
// HTTP Host extractor. Takes one TCP payload byte per request, with first and
// final marks, checks for "GET /" or "POST /", skips the URI to the first space,
// requires " HTTP/1.1\r\nHost: " and returns the host name one byte per response,
// dropping one trailing dot. Each payload that starts ends with one closing
// response (is_last high) whose kind gives done or the error. The parser takes
// one byte per cycle while req_ready is high. A byte can yield up to two responses;
// these enter a four-entry queue when the byte is accepted and leave from its head
// at one per cycle while rsp_ready is high. Two-response bytes never come often
// enough to outrun the response port, so with a ready receiver the input takes
// a byte every cycle; req_ready drops only when a stalled receiver lets the queue fill.
module http_host_extractor
   import hhe_pkg::*;
#(
   parameter int MAX_NAME_LEN = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_host_char,
   output logic [2:0] rsp_kind,
   output logic       rsp_is_last
);

   logic      push, pop, empty, full;
   entry_type push_entry, head;

   assign req_ready = !full;

   hhe_front #(
      .MAX_NAME_LEN(MAX_NAME_LEN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_final_byte (req_final_byte),
      .push           (push),
      .entry          (push_entry)
   );

   hhe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   hhe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_host_char (rsp_host_char),
      .rsp_kind      (rsp_kind),
      .rsp_is_last   (rsp_is_last)
   );

endmodule
